// ===== hw/rtl/owrs_pkg.sv =====
package owrs_pkg;

    typedef enum logic [1:0] {
        REQ_FIRST    = 2'd0,
        REQ_NEXT     = 2'd1,
        REQ_RESET_ST = 2'd2,
        REQ_TRIP_ST  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        KIND_BUS_RESET = 3'd0,
        KIND_WRITE     = 3'd1,
        KIND_TRIPLET   = 3'd2,
        KIND_ROM       = 3'd3,
        KIND_DONE      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_TRIP  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        RUN_FAIL  = 3'd0,
        RUN_RESET = 3'd1,
        RUN_CMD   = 3'd2,
        RUN_TRIP  = 3'd3,
        RUN_ROM   = 3'd4
    } run_t;

    typedef struct packed {
        run_t       run;
        logic       dir;
        logic [3:0] fam;
    } desc_t;

    localparam logic [7:0] CRC_POLY     = 8'h8C;
    localparam logic [7:0] CMD_DEFAULT  = 8'hF0;
    localparam logic [6:0] BIT_END      = 7'd65;
    localparam logic [6:0] FAMILY_LIMIT = 7'd9;
    localparam logic [3:0] DONE_BEAT    = 4'd8;

    localparam int ST_PRESENCE = 1;
    localparam int ST_ID       = 5;
    localparam int ST_CMP      = 6;
    localparam int ST_DIR      = 7;

    function automatic logic [7:0] crc8_byte(input logic [7:0] d);
        logic [7:0] c;
        c = d;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/owrs_step.sv =====
module owrs_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [7:0]           status_byte,
    input  logic                 emit_free,
    output logic                 load,
    output owrs_pkg::desc_t      desc,
    output logic [63:0]          rom
);
    import owrs_pkg::*;

    logic        in_full_reg;
    logic [1:0]  req_reg;
    logic [7:0]  status_reg;

    logic [63:0] rom_reg, rom_next;
    logic [6:0]  ld_reg, ld_next;
    logic [3:0]  lfd_reg, lfd_next;
    logic        ldseen_reg, ldseen_next;
    logic [6:0]  pos_reg, pos_next;
    logic [6:0]  lz_reg, lz_next;
    logic [7:0]  crc_reg, crc_next;
    phase_t      phase_reg, phase_next;

    logic        fire;
    logic        idb, cmp, dirb, zero_taken;
    logic [6:0]  pm, pos_inc, lz_t;
    logic [3:0]  lfd_t;
    logic [63:0] rom_new;
    logic [7:0]  byte_new, crc_new;

    function automatic logic choose_dir(input logic [6:0] p, input logic [6:0] ld,
                                        input logic [63:0] r);
        logic [6:0] q;
        q = p - 7'd1;
        if (p < ld) begin
            return r[q[5:0]];
        end
        return (p == ld);
    endfunction

    assign fire     = in_full_reg && emit_free;
    assign in_ready = !in_full_reg || fire;
    assign rom      = rom_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready) begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            req_reg    <= req_type;
            status_reg <= status_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rom_reg    <= '0;
            ld_reg     <= '0;
            lfd_reg    <= '0;
            ldseen_reg <= 1'b0;
            pos_reg    <= 7'd1;
            lz_reg     <= '0;
            crc_reg    <= '0;
            phase_reg  <= PH_IDLE;
        end
        else begin
            rom_reg    <= rom_next;
            ld_reg     <= ld_next;
            lfd_reg    <= lfd_next;
            ldseen_reg <= ldseen_next;
            pos_reg    <= pos_next;
            lz_reg     <= lz_next;
            crc_reg    <= crc_next;
            phase_reg  <= phase_next;
        end
    end

    always_comb begin
        idb        = status_reg[ST_ID];
        cmp        = status_reg[ST_CMP];
        dirb       = status_reg[ST_DIR];
        zero_taken = !idb && !cmp && !dirb;
        pm         = pos_reg - 7'd1;
        pos_inc    = pos_reg + 7'd1;
        lz_t       = zero_taken ? pos_reg : lz_reg;
        lfd_t      = (zero_taken && (pos_reg < FAMILY_LIMIT)) ? pos_reg[3:0] : lfd_reg;
        rom_new    = rom_reg;
        rom_new[pm[5:0]] = dirb;
        byte_new   = rom_new[{pm[5:3], 3'b000} +: 8];
        crc_new    = (pm[2:0] == 3'd7) ? crc8_byte(crc_reg ^ byte_new) : crc_reg;

        rom_next    = rom_reg;
        ld_next     = ld_reg;
        lfd_next    = lfd_reg;
        ldseen_next = ldseen_reg;
        pos_next    = pos_reg;
        lz_next     = lz_reg;
        crc_next    = crc_reg;
        phase_next  = phase_reg;
        load        = 1'b0;
        desc.run    = RUN_FAIL;
        desc.dir    = 1'b0;

        if (fire) begin
            case (req_t'(req_reg))
                REQ_FIRST, REQ_NEXT: begin
                    if (req_t'(req_reg) == REQ_FIRST) begin
                        ld_next     = '0;
                        lfd_next    = '0;
                        ldseen_next = 1'b0;
                    end
                    pos_next = 7'd1;
                    lz_next  = '0;
                    crc_next = '0;
                    load     = 1'b1;
                    if (req_t'(req_reg) == REQ_NEXT && ldseen_reg) begin
                        ld_next     = '0;
                        lfd_next    = '0;
                        ldseen_next = 1'b0;
                        phase_next  = PH_IDLE;
                        desc.run    = RUN_FAIL;
                    end
                    else begin
                        phase_next = PH_RESET;
                        desc.run   = RUN_RESET;
                    end
                end
                REQ_RESET_ST: begin
                    if (phase_reg == PH_RESET) begin
                        load = 1'b1;
                        if (!status_reg[ST_PRESENCE]) begin
                            ld_next     = '0;
                            lfd_next    = '0;
                            ldseen_next = 1'b0;
                            phase_next  = PH_IDLE;
                            desc.run    = RUN_FAIL;
                        end
                        else begin
                            phase_next = PH_TRIP;
                            desc.run   = RUN_CMD;
                            desc.dir   = choose_dir(pos_reg, ld_reg, rom_reg);
                        end
                    end
                end
                REQ_TRIP_ST: begin
                    if (phase_reg == PH_TRIP) begin
                        load = 1'b1;
                        if (idb && cmp) begin
                            ld_next     = '0;
                            lfd_next    = '0;
                            ldseen_next = 1'b0;
                            phase_next  = PH_IDLE;
                            desc.run    = RUN_FAIL;
                        end
                        else begin
                            lz_next  = lz_t;
                            lfd_next = lfd_t;
                            rom_next = rom_new;
                            crc_next = crc_new;
                            pos_next = pos_inc;
                            if (pos_inc >= BIT_END) begin
                                phase_next = PH_IDLE;
                                if (crc_new != 8'd0 || rom_new[7:0] == 8'd0) begin
                                    ld_next     = '0;
                                    lfd_next    = '0;
                                    ldseen_next = 1'b0;
                                    desc.run    = RUN_FAIL;
                                end
                                else begin
                                    ld_next = lz_t;
                                    if (lz_t == 7'd0) begin
                                        ldseen_next = 1'b1;
                                    end
                                    desc.run = RUN_ROM;
                                end
                            end
                            else begin
                                desc.run = RUN_TRIP;
                                desc.dir = choose_dir(pos_inc, ld_reg, rom_new);
                            end
                        end
                    end
                end
                default: begin
                    load = 1'b0;
                end
            endcase
        end
        desc.fam = lfd_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ldseen_reg |-> (ld_reg == 7'd0))
        else $error("last device flag set with a pending discrepancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TRIP) |-> (pos_reg >= 7'd1 && pos_reg < BIT_END))
        else $error("bit position out of range during triplets");

    assert property (@(posedge clk) disable iff (!rst_n)
        {3'b000, lfd_reg} < FAMILY_LIMIT)
        else $error("family discrepancy outside the family byte");

endmodule

// ===== hw/rtl/owrs_emit.sv =====
module owrs_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  logic                 load,
    input  owrs_pkg::desc_t      desc,
    input  logic [63:0]          rom,
    output logic                 emit_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           out_kind,
    output logic [7:0]           out_byte,
    output logic                 triplet_direction,
    output logic                 found,
    output logic [3:0]           family_discrepancy,
    output logic                 last_of_run
);
    import owrs_pkg::*;

    logic        valid_reg;
    desc_t       desc_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  cmd_reg;
    kind_t       kind;
    logic        last_beat;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_reg <= CMD_DEFAULT;
        end
        else if (cfg_we) begin
            cmd_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (load) begin
            valid_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (valid_reg && out_ready) begin
            if (last_beat) begin
                valid_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            desc_reg <= desc;
        end
    end

    always_comb begin
        kind              = KIND_DONE;
        out_byte          = 8'd0;
        triplet_direction = 1'b0;
        found             = 1'b0;
        last_beat         = 1'b1;
        case (desc_reg.run)
            RUN_FAIL: begin
                kind = KIND_DONE;
            end
            RUN_RESET: begin
                kind = KIND_BUS_RESET;
            end
            RUN_CMD: begin
                if (cnt_reg == 4'd0) begin
                    kind      = KIND_WRITE;
                    out_byte  = cmd_reg;
                    last_beat = 1'b0;
                end
                else begin
                    kind              = KIND_TRIPLET;
                    triplet_direction = desc_reg.dir;
                end
            end
            RUN_TRIP: begin
                kind              = KIND_TRIPLET;
                triplet_direction = desc_reg.dir;
            end
            RUN_ROM: begin
                if (cnt_reg == DONE_BEAT) begin
                    kind  = KIND_DONE;
                    found = 1'b1;
                end
                else begin
                    kind      = KIND_ROM;
                    out_byte  = rom[{cnt_reg[2:0], 3'b000} +: 8];
                    last_beat = 1'b0;
                end
            end
            default: begin
                kind = KIND_DONE;
            end
        endcase
    end

    assign emit_free          = !valid_reg || (out_ready && last_beat);
    assign out_valid          = valid_reg;
    assign out_kind           = kind;
    assign family_discrepancy = desc_reg.fam;
    assign last_of_run        = last_beat;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DONE_BEAT)
        else $error("beat counter past the done beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> (cnt_reg == 4'd0))
        else $error("beat counter not cleared while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && desc_reg.run != RUN_ROM) |-> (cnt_reg <= 4'd1))
        else $error("short run went past its second beat");

endmodule

// ===== hw/rtl/onewire_rom_search_engine_unit.sv =====
// One-Wire ROM search controller. Each request beat (start, bus reset status or triplet status)
// is captured in an input register, applied to the search state when the result register is free,
// and turned into a run of one to nine result beats held in a result register: a bus reset, a
// command byte and the first triplet, a next triplet, the eight ROM bytes followed by done, or a
// lone done on failure. One-beat requests flow at one per cycle while out_ready is high; a request
// that produces several beats holds the input side until its last beat is taken, since the result
// register sends one beat per cycle while out_ready is high. Wrong-phase status beats are dropped.
module onewire_rom_search_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  status_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic        triplet_direction,
    output logic        found,
    output logic [3:0]  family_discrepancy,
    output logic        last_of_run
);
    import owrs_pkg::*;

    logic        emit_free;
    logic        load;
    desc_t       desc;
    logic [63:0] rom;

    owrs_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .status_byte (status_byte),
        .emit_free   (emit_free),
        .load        (load),
        .desc        (desc),
        .rom         (rom)
    );

    owrs_emit u_emit (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .load               (load),
        .desc               (desc),
        .rom                (rom),
        .emit_free          (emit_free),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_kind           (out_kind),
        .out_byte           (out_byte),
        .triplet_direction  (triplet_direction),
        .found              (found),
        .family_discrepancy (family_discrepancy),
        .last_of_run        (last_of_run)
    );

endmodule
